// File: hw/rtl/lces_pkg.sv
// Shared types and constants for the LED chase effect sequencer.
`default_nettype none

package lces_pkg;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_SELECT = 2'd1,
        REQ_TOGGLE = 2'd2,
        REQ_NONE   = 2'd3
    } lces_req_t;

    // Switch modes
    localparam logic [2:0] MODE_CYCLE   = 3'd0;
    localparam logic [2:0] MODE_INWARD  = 3'd1;
    localparam logic [2:0] MODE_OUTWARD = 3'd2;
    localparam logic [2:0] MODE_BOUNCE  = 3'd3;
    localparam logic [2:0] MODE_CHASE   = 3'd4;

    // Parts of the all-effects cycle
    localparam logic [1:0] PART_CHASE   = 2'd0;
    localparam logic [1:0] PART_BOUNCE  = 2'd1;
    localparam logic [1:0] PART_OUTWARD = 2'd2;
    localparam logic [1:0] PART_INWARD  = 2'd3;

    // LED patterns
    localparam logic [4:0] PAT_BLANK  = 5'h00;
    localparam logic [4:0] PAT_FIRST  = 5'h01;
    localparam logic [4:0] PAT_LAST   = 5'h10;
    localparam logic [4:0] PAT_CENTRE = 5'h04;
    localparam logic [4:0] PAT_MIDDLE = 5'h0A;
    localparam logic [4:0] PAT_EDGES  = 5'h11;

    // Sequencer state
    typedef struct packed {
        logic [4:0] pattern;
        logic [2:0] mode;
        logic       enabled;
        logic       bounce_dir;
        logic [1:0] three_step_phase;
        logic [1:0] inward_phase;
        logic [1:0] cycle_part;
    } lces_state_t;

    // Result word fields
    typedef struct packed {
        logic [2:0] active_mode;
        logic       lights_enabled;
        logic [4:0] led_pattern;
    } lces_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/led_chase_effect_sequencer_unit.sv
// The result word for an accepted input word is registered and appears on m_tdata in the cycle after it is accepted.
// Throughput: one word per cycle while s_tready is high; the effect state and result register update together.
// s_tready drops only while a result word waits and m_tready is low.
// Reset (aresetn low, synchronous): blank pattern, mode 0, effects enabled,
// all step counters cleared, no result word pending.
`default_nettype none

module led_chase_effect_sequencer_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [2:0] new_mode, [7:3] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [4:0] led_pattern, [5] lights_enabled,
                                        // [8:6] active_mode, [15:9] zero
);
    import lces_pkg::*;

    logic         accept;
    logic         space;
    lces_result_t result_next;

    // Take a word whenever the result register has room
    assign s_tready = space;
    assign accept   = s_tvalid && space;

    lces_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .req_type    (s_tuser),
        .new_mode    (s_tdata[2:0]),
        .result_next (result_next)
    );

    lces_out_reg u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (accept),
        .result_next (result_next),
        .space       (space),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

// File: hw/rtl/lces_core.sv
// Effect state registers and their single-pass next-state logic.
`default_nettype none

module lces_core (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire logic [1:0]            req_type,
    input  wire logic [2:0]            new_mode,
    output lces_pkg::lces_result_t     result_next
);
    import lces_pkg::*;

    lces_state_t state_reg;
    lces_state_t state_next;
    lces_req_t   req;

    assign req = lces_req_t'(req_type);

    // Compute the state after one request
    always_comb begin
        logic [4:0] shl;
        logic [4:0] shr;
        shl = {state_reg.pattern[3:0], 1'b0};
        shr = {1'b0, state_reg.pattern[4:1]};
        state_next = state_reg;
        unique case (req)
            REQ_TICK: begin
                if (state_reg.enabled) begin
                    unique case (state_reg.mode)
                        MODE_CYCLE: begin
                            unique case (state_reg.cycle_part)
                                PART_CHASE: begin
                                    state_next.pattern = shl;
                                    if (shl == PAT_BLANK) begin
                                        state_next.pattern    = PAT_FIRST;
                                        state_next.cycle_part = PART_BOUNCE;
                                    end
                                end
                                PART_BOUNCE: begin
                                    if (!state_reg.bounce_dir) begin
                                        state_next.pattern = shl;
                                        if (shl == PAT_LAST) state_next.bounce_dir = 1'b1;
                                    end else begin
                                        state_next.pattern = shr;
                                        if (shr == PAT_FIRST) begin
                                            state_next.bounce_dir = 1'b0;
                                            state_next.cycle_part = PART_OUTWARD;
                                        end
                                    end
                                end
                                PART_OUTWARD: begin
                                    if (state_reg.three_step_phase == 2'd0) begin
                                        state_next.pattern          = PAT_CENTRE;
                                        state_next.three_step_phase = 2'd1;
                                    end else if (state_reg.three_step_phase == 2'd1) begin
                                        state_next.pattern          = PAT_MIDDLE;
                                        state_next.three_step_phase = 2'd2;
                                    end else begin
                                        state_next.pattern          = PAT_EDGES;
                                        state_next.three_step_phase = 2'd0;
                                        state_next.cycle_part       = PART_INWARD;
                                    end
                                end
                                default: begin
                                    if (state_reg.inward_phase == 2'd0) begin
                                        state_next.pattern      = PAT_EDGES;
                                        state_next.inward_phase = 2'd1;
                                    end else if (state_reg.inward_phase == 2'd1) begin
                                        state_next.pattern      = PAT_MIDDLE;
                                        state_next.inward_phase = 2'd2;
                                    end else begin
                                        state_next.pattern      = PAT_CENTRE;
                                        state_next.inward_phase = 2'd0;
                                        state_next.cycle_part   = PART_CHASE;
                                    end
                                end
                            endcase
                        end
                        MODE_INWARD, MODE_OUTWARD: begin
                            if (state_reg.three_step_phase == 2'd0) begin
                                state_next.pattern = (state_reg.mode == MODE_INWARD)
                                                     ? PAT_EDGES : PAT_CENTRE;
                                state_next.three_step_phase = 2'd1;
                            end else if (state_reg.three_step_phase == 2'd1) begin
                                state_next.pattern          = PAT_MIDDLE;
                                state_next.three_step_phase = 2'd2;
                            end else begin
                                state_next.pattern = (state_reg.mode == MODE_INWARD)
                                                     ? PAT_CENTRE : PAT_EDGES;
                                state_next.three_step_phase = 2'd0;
                            end
                        end
                        MODE_BOUNCE: begin
                            if (!state_reg.bounce_dir) begin
                                state_next.pattern = shl;
                                if (shl == PAT_LAST) state_next.bounce_dir = 1'b1;
                            end else begin
                                state_next.pattern = shr;
                                if (shr == PAT_FIRST) state_next.bounce_dir = 1'b0;
                            end
                        end
                        MODE_CHASE: begin
                            state_next.pattern = (shl == PAT_BLANK) ? PAT_FIRST : shl;
                        end
                        default: begin
                            // blank modes ignore ticks
                        end
                    endcase
                end
            end
            REQ_SELECT: begin
                state_next.mode = new_mode;
                unique case (new_mode)
                    MODE_CYCLE: begin
                        state_next.pattern          = PAT_FIRST;
                        state_next.bounce_dir       = 1'b0;
                        state_next.three_step_phase = 2'd0;
                        state_next.inward_phase     = 2'd0;
                        state_next.cycle_part       = PART_CHASE;
                    end
                    MODE_INWARD: begin
                        state_next.pattern          = PAT_EDGES;
                        state_next.three_step_phase = 2'd0;
                    end
                    MODE_OUTWARD: begin
                        state_next.pattern          = PAT_CENTRE;
                        state_next.three_step_phase = 2'd0;
                    end
                    MODE_BOUNCE: begin
                        state_next.pattern    = PAT_FIRST;
                        state_next.bounce_dir = 1'b0;
                    end
                    MODE_CHASE: begin
                        state_next.pattern = PAT_FIRST;
                    end
                    default: begin
                        state_next.pattern = PAT_BLANK;
                    end
                endcase
            end
            REQ_TOGGLE: begin
                state_next.enabled = ~state_reg.enabled;
            end
            default: begin
                // unused request code: hold state
            end
        endcase
    end

    // Advance state on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{pattern: PAT_BLANK, mode: MODE_CYCLE, enabled: 1'b1,
                           bounce_dir: 1'b0, three_step_phase: 2'd0,
                           inward_phase: 2'd0, cycle_part: PART_CHASE};
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Result fields follow the new state
    assign result_next.led_pattern    = state_next.pattern;
    assign result_next.lights_enabled = state_next.enabled;
    assign result_next.active_mode    = state_next.mode;

endmodule

`default_nettype wire

// File: hw/rtl/lces_out_reg.sv
// Result register for the master stream side.
`default_nettype none

module lces_out_reg (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  load,
    input  wire lces_pkg::lces_result_t result_next,
    output logic                       space,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [15:0]                m_tdata
);
    import lces_pkg::*;

    logic         valid_reg;
    lces_result_t data_reg;

    // Room for a new word when empty or when the held word leaves now
    assign space = !valid_reg || m_tready;

    // Track the held word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Load result data
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, data_reg};

endmodule

`default_nettype wire
